[hdl/bsf_pkg.sv]
// Shared constants and helpers for the bond spring force pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none
package bsf_pkg;
    localparam int COORD_WIDTH_DEF      = 32;
    localparam int ATOM_INDEX_WIDTH_DEF = 16;
    localparam int K_W                  = 32;
    localparam int REST_W               = 32;
    localparam int FORCE_W              = 32;
    localparam int FORCE_SHIFT          = 17;

    function automatic int byte_round(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

    function automatic int max_of(input int a, input int b);
        return (a > b) ? a : b;
    endfunction
endpackage
`default_nettype wire

[hdl/bsf_front.sv]
// Front stages: coordinate difference, squares and squared length.
// Depends on bsf_pkg.
`default_nettype none
module bsf_front
    import bsf_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int PW = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [6*CW-1:0]   in_pos,   // p1x, p1y, p1z, p2x, p2y, p2z from bit 0 up
    input  logic [PW-1:0]     in_pay,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2*CW+1:0]   out_s,
    output logic [3*CW-1:0]   out_mag,
    output logic [2:0]        out_sign,
    output logic              out_zero,
    output logic [PW-1:0]     out_pay
);
    logic              v1_reg, v2_reg, v3_reg;
    logic              adv1, adv2, adv3;
    logic [3*CW-1:0]   mag1_reg, mag2_reg, mag3_reg;
    logic [2:0]        sign1_reg, sign2_reg, sign3_reg;
    logic [PW-1:0]     pay1_reg, pay2_reg, pay3_reg;
    logic [2*CW-1:0]   sq2_reg [3];
    logic              zero2_reg, zero3_reg;
    logic [2*CW+1:0]   s3_reg;
    logic [3*CW-1:0]   mag1_next;
    logic [2:0]        sign1_next;
    logic [2*CW+1:0]   s3_next;

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb begin
        logic [CW:0] d;
        logic [CW:0] m;
        mag1_next  = '0;
        sign1_next = '0;
        for (int i = 0; i < 3; i++) begin
            d = {in_pos[i*CW+CW-1], in_pos[i*CW +: CW]}
              - {in_pos[(3+i)*CW+CW-1], in_pos[(3+i)*CW +: CW]};
            m = d[CW] ? (~d + (CW+1)'(1)) : d;
            sign1_next[i] = d[CW];
            mag1_next[i*CW +: CW] = m[CW-1:0];
        end
    end

    always_comb begin
        s3_next = '0;
        for (int i = 0; i < 3; i++) begin
            s3_next = s3_next + {2'b00, sq2_reg[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
        if (adv1 && in_valid) begin
            mag1_reg  <= mag1_next;
            sign1_reg <= sign1_next;
            pay1_reg  <= in_pay;
        end
        if (adv2 && v1_reg) begin
            for (int i = 0; i < 3; i++) begin
                sq2_reg[i] <= {{CW{1'b0}}, mag1_reg[i*CW +: CW]}
                            * {{CW{1'b0}}, mag1_reg[i*CW +: CW]};
            end
            zero2_reg <= (mag1_reg == '0);
            mag2_reg  <= mag1_reg;
            sign2_reg <= sign1_reg;
            pay2_reg  <= pay1_reg;
        end
        if (adv3 && v2_reg) begin
            s3_reg    <= s3_next;
            zero3_reg <= zero2_reg;
            mag3_reg  <= mag2_reg;
            sign3_reg <= sign2_reg;
            pay3_reg  <= pay2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_s     = s3_reg;
    assign out_mag   = mag3_reg;
    assign out_sign  = sign3_reg;
    assign out_zero  = zero3_reg;
    assign out_pay   = pay3_reg;
endmodule
`default_nettype wire

[hdl/bsf_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
// Depends on bsf_pkg.
`default_nettype none
module bsf_sqrt
    import bsf_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int PW = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2*CW+1:0]   in_s,
    input  logic [PW-1:0]     in_pay,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CW:0]       out_r,
    output logic [PW-1:0]     out_pay
);
    localparam int SW = 2 * CW + 2;
    localparam int RW = CW + 1;

    logic            v_reg    [1:RW];
    logic [SW-1:0]   rem_reg  [1:RW];
    logic [RW-1:0]   root_reg [1:RW];
    logic [PW-1:0]   pay_reg  [1:RW];
    logic [RW+1:1]   adv;

    assign adv[RW+1] = out_ready;
    assign in_ready  = adv[1];

    for (genvar j = 1; j <= RW; j++) begin : g_stage
        localparam int B = RW - j;
        logic            v_prev;
        logic [SW-1:0]   rem_prev;
        logic [RW-1:0]   root_prev;
        logic [PW-1:0]   pay_prev;
        logic [SW:0]     trial;
        logic [SW:0]     diff;
        logic            take;

        if (j == 1) begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = in_s;
            assign root_prev = '0;
            assign pay_prev  = in_pay;
        end else begin : g_next
            assign v_prev    = v_reg[j-1];
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign pay_prev  = pay_reg[j-1];
        end

        assign adv[j] = !v_reg[j] || adv[j+1];

        always_comb begin
            trial = ({{(SW+1-RW){1'b0}}, root_prev} << (B + 1))
                  + ((SW+1)'(1) << (2 * B));
            diff  = {1'b0, rem_prev} - trial;
            take  = ({1'b0, rem_prev} >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (adv[j]) begin
                v_reg[j] <= v_prev;
            end
            if (adv[j] && v_prev) begin
                rem_reg[j]  <= take ? diff[SW-1:0] : rem_prev;
                root_reg[j] <= take ? (root_prev | (RW'(1) << B)) : root_prev;
                pay_reg[j]  <= pay_prev;
            end
        end
    end

    assign out_valid = v_reg[RW];
    assign out_r     = root_reg[RW];
    assign out_pay   = pay_reg[RW];
endmodule
`default_nettype wire

[hdl/bsf_div.sv]
// Scales rest length by each axis magnitude, then divides by the length
// in a restoring pipeline, one quotient bit per stage. Depends on bsf_pkg.
`default_nettype none
module bsf_div
    import bsf_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int PW = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CW:0]          in_r,
    input  logic [3*CW-1:0]      in_mag,
    input  logic [REST_W-1:0]    in_rest,
    input  logic [PW-1:0]        in_pay,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3*REST_W-1:0]  out_q,
    output logic [PW-1:0]        out_pay
);
    localparam int RW = CW + 1;
    localparam int QW = REST_W;
    localparam int NW = REST_W + CW;
    localparam int N  = QW + 1;

    logic            v_reg   [1:N];
    logic [RW-1:0]   rem_reg [1:N][3];
    logic [QW-1:0]   lo_reg  [1:N][3];
    logic [RW-1:0]   r_reg   [1:N];
    logic [PW-1:0]   pay_reg [1:N];
    logic [N+1:1]    adv;

    assign adv[N+1]  = out_ready;
    assign in_ready  = adv[1];
    assign adv[1]    = !v_reg[1] || adv[2];

    always_ff @(posedge aclk) begin
        logic [NW-1:0] n;
        if (!aresetn) begin
            v_reg[1] <= 1'b0;
        end else if (adv[1]) begin
            v_reg[1] <= in_valid;
        end
        if (adv[1] && in_valid) begin
            for (int i = 0; i < 3; i++) begin
                n = {{CW{1'b0}}, in_rest} * {{REST_W{1'b0}}, in_mag[i*CW +: CW]};
                rem_reg[1][i] <= {1'b0, n[NW-1 -: CW]};
                lo_reg[1][i]  <= n[QW-1:0];
            end
            r_reg[1]   <= in_r;
            pay_reg[1] <= in_pay;
        end
    end

    for (genvar j = 2; j <= N; j++) begin : g_stage
        assign adv[j] = !v_reg[j] || adv[j+1];

        always_ff @(posedge aclk) begin
            logic [RW:0] t;
            logic [RW:0] dn;
            logic        take;
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (adv[j]) begin
                v_reg[j] <= v_reg[j-1];
            end
            if (adv[j] && v_reg[j-1]) begin
                for (int i = 0; i < 3; i++) begin
                    t    = {rem_reg[j-1][i], lo_reg[j-1][i][QW-1]};
                    take = (t >= {1'b0, r_reg[j-1]});
                    dn   = take ? (t - {1'b0, r_reg[j-1]}) : t;
                    rem_reg[j][i] <= dn[RW-1:0];
                    lo_reg[j][i]  <= {lo_reg[j-1][i][QW-2:0], take};
                end
                r_reg[j]   <= r_reg[j-1];
                pay_reg[j] <= pay_reg[j-1];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_q     = {lo_reg[N][2], lo_reg[N][1], lo_reg[N][0]};
    assign out_pay   = pay_reg[N];
endmodule
`default_nettype wire

[hdl/bsf_force.sv]
// Back stages: spring extension, scaling by k, right shift by FORCE_SHIFT and saturation.
// Depends on bsf_pkg.
`default_nettype none
module bsf_force
    import bsf_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int IW = ATOM_INDEX_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [3*REST_W-1:0]   in_q,
    input  logic [3*CW-1:0]       in_mag,
    input  logic [2:0]            in_sign,
    input  logic                  in_zero,
    input  logic [K_W-1:0]        in_k,
    input  logic [2*IW-1:0]       in_idx,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [3*FORCE_W-1:0]  out_force,
    output logic                  out_zero,
    output logic [2*IW-1:0]       out_idx
);
    localparam int AW  = max_of(CW, REST_W);
    localparam int EW  = AW + 1;
    localparam int PRW = K_W + AW;

    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic                adv1, adv2, adv3, adv4;
    logic [EW-1:0]       u1_reg  [3];
    logic [AW-1:0]       a2_reg  [3];
    logic [PRW-1:0]      p3_reg  [3];
    logic [2:0]          s1_reg, neg2_reg, neg3_reg;
    logic [K_W-1:0]      k1_reg, k2_reg;
    logic                z1_reg, z2_reg, z3_reg, z4_reg;
    logic [2*IW-1:0]     id1_reg, id2_reg, id3_reg, id4_reg;
    logic [3*FORCE_W-1:0] f4_reg, f4_next;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb begin
        logic [PRW-1:0] sh;
        logic [FORCE_W-1:0] f;
        f4_next = '0;
        for (int i = 0; i < 3; i++) begin
            sh = p3_reg[i] >> FORCE_SHIFT;
            if (z3_reg) begin
                f = '0;
            end else if (!neg3_reg[i]) begin
                f = (sh > PRW'({1'b0, {(FORCE_W-1){1'b1}}})) ?
                    {1'b0, {(FORCE_W-1){1'b1}}} : sh[FORCE_W-1:0];
            end else begin
                f = (sh > PRW'({1'b1, {(FORCE_W-1){1'b0}}})) ?
                    {1'b1, {(FORCE_W-1){1'b0}}} : (~sh[FORCE_W-1:0] + FORCE_W'(1));
            end
            f4_next[i*FORCE_W +: FORCE_W] = f;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
        if (adv1 && in_valid) begin
            for (int i = 0; i < 3; i++) begin
                u1_reg[i] <= EW'(in_mag[i*CW +: CW]) - EW'(in_q[i*REST_W +: REST_W]);
            end
            s1_reg  <= in_sign;
            k1_reg  <= in_k;
            z1_reg  <= in_zero;
            id1_reg <= in_idx;
        end
        if (adv2 && v1_reg) begin
            for (int i = 0; i < 3; i++) begin
                a2_reg[i]   <= u1_reg[i][EW-1] ? AW'(~u1_reg[i] + EW'(1)) : u1_reg[i][AW-1:0];
                neg2_reg[i] <= s1_reg[i] ^ u1_reg[i][EW-1];
            end
            k2_reg  <= k1_reg;
            z2_reg  <= z1_reg;
            id2_reg <= id1_reg;
        end
        if (adv3 && v2_reg) begin
            for (int i = 0; i < 3; i++) begin
                p3_reg[i] <= {{AW{1'b0}}, k2_reg} * {{K_W{1'b0}}, a2_reg[i]};
            end
            neg3_reg <= neg2_reg;
            z3_reg   <= z2_reg;
            id3_reg  <= id2_reg;
        end
        if (adv4 && v3_reg) begin
            f4_reg  <= f4_next;
            z4_reg  <= z3_reg;
            id4_reg <= id3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_force = f4_reg;
    assign out_zero  = z4_reg;
    assign out_idx   = id4_reg;
endmodule
`default_nettype wire

[hdl/bond_spring_force_core.sv]
// Top level of the harmonic bond force pipeline.
// Depends on bsf_pkg, bsf_front, bsf_sqrt, bsf_div and bsf_force.
//
//   channel | dir | tdata (low bit up)                                   | tuser
//   s_      | in  | first/second atom, first x/y/z, second x/y/z, k, rest | -
//   m_      | out | out first/second atom, force x/y/z                   | zero_length
//
// One bond per cycle sustained while m_tready is high. The pipeline depth is set
// mostly by the bit-per-stage square root and divider.
// aresetn clears every valid bit; payload registers are not reset.
// A stall at m_ holds the result; input is taken as long as any stage has a hole.
`default_nettype none
module bond_spring_force_core
    import bsf_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int ATOM_INDEX_WIDTH = ATOM_INDEX_WIDTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    // first_atom, second_atom, first_x, first_y, first_z, second_x, second_y,
    // second_z, spring_constant, rest_length, zero fill
    input  logic [byte_round(2*ATOM_INDEX_WIDTH+6*COORD_WIDTH+K_W+REST_W)-1:0] s_tdata,
    output logic  m_tvalid,
    input  logic  m_tready,
    // out_first_atom, out_second_atom, force_x, force_y, force_z, zero fill
    output logic [byte_round(2*ATOM_INDEX_WIDTH+3*FORCE_W)-1:0] m_tdata,
    output logic [0:0] m_tuser   // zero_length
);
    localparam int CW   = COORD_WIDTH;
    localparam int IW   = ATOM_INDEX_WIDTH;
    localparam int M_DW = byte_round(2*IW + 3*FORCE_W);

    typedef struct packed {
        logic [REST_W-1:0] rest;
        logic [K_W-1:0]    k;
        logic [2*IW-1:0]   idx;
    } side_t;

    typedef struct packed {
        side_t           side;
        logic [3*CW-1:0] mag;
        logic [2:0]      sign;
        logic            zero;
    } root_pay_t;

    typedef struct packed {
        logic [K_W-1:0]  k;
        logic [2*IW-1:0] idx;
        logic [3*CW-1:0] mag;
        logic [2:0]      sign;
        logic            zero;
    } div_pay_t;

    side_t       in_side, fr_side;
    root_pay_t   sq_in_pay, sq_out_pay;
    div_pay_t    dv_in_pay, dv_out_pay;
    logic        fr_valid, fr_ready, sq_valid, sq_ready, dv_valid, dv_ready;
    logic [2*CW+1:0]      fr_s;
    logic [3*CW-1:0]      fr_mag;
    logic [2:0]           fr_sign;
    logic                 fr_zero;
    logic [CW:0]          sq_r;
    logic [3*REST_W-1:0]  dv_q;
    logic [3*FORCE_W-1:0] fc_force;
    logic                 fc_zero;
    logic [2*IW-1:0]      fc_idx;

    assign in_side.idx  = s_tdata[2*IW-1:0];
    assign in_side.k    = s_tdata[2*IW+6*CW +: K_W];
    assign in_side.rest = s_tdata[2*IW+6*CW+K_W +: REST_W];

    bsf_front #(.CW(CW), .PW($bits(side_t))) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pos    (s_tdata[2*IW +: 6*CW]),
        .in_pay    (in_side),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_s     (fr_s),
        .out_mag   (fr_mag),
        .out_sign  (fr_sign),
        .out_zero  (fr_zero),
        .out_pay   (fr_side)
    );

    assign sq_in_pay.side = fr_side;
    assign sq_in_pay.mag  = fr_mag;
    assign sq_in_pay.sign = fr_sign;
    assign sq_in_pay.zero = fr_zero;

    bsf_sqrt #(.CW(CW), .PW($bits(root_pay_t))) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_s      (fr_s),
        .in_pay    (sq_in_pay),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_r     (sq_r),
        .out_pay   (sq_out_pay)
    );

    assign dv_in_pay.k    = sq_out_pay.side.k;
    assign dv_in_pay.idx  = sq_out_pay.side.idx;
    assign dv_in_pay.mag  = sq_out_pay.mag;
    assign dv_in_pay.sign = sq_out_pay.sign;
    assign dv_in_pay.zero = sq_out_pay.zero;

    bsf_div #(.CW(CW), .PW($bits(div_pay_t))) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_r      (sq_r),
        .in_mag    (sq_out_pay.mag),
        .in_rest   (sq_out_pay.side.rest),
        .in_pay    (dv_in_pay),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_q     (dv_q),
        .out_pay   (dv_out_pay)
    );

    bsf_force #(.CW(CW), .IW(IW)) u_force (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_q      (dv_q),
        .in_mag    (dv_out_pay.mag),
        .in_sign   (dv_out_pay.sign),
        .in_zero   (dv_out_pay.zero),
        .in_k      (dv_out_pay.k),
        .in_idx    (dv_out_pay.idx),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_force (fc_force),
        .out_zero  (fc_zero),
        .out_idx   (fc_idx)
    );

    assign m_tdata  = M_DW'({fc_force, fc_idx});
    assign m_tuser  = fc_zero;
endmodule
`default_nettype wire

[hdl/bsf_checker.sv]
// Port-level checks for bond_spring_force_core, attached by bind.
// Depends on bsf_pkg.
`default_nettype none
module bsf_checker
    import bsf_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int ATOM_INDEX_WIDTH = ATOM_INDEX_WIDTH_DEF
) (
    input logic  aclk,
    input logic  aresetn,
    input logic  s_tvalid,
    input logic  s_tready,
    input logic [byte_round(2*ATOM_INDEX_WIDTH+6*COORD_WIDTH+K_W+REST_W)-1:0] s_tdata,
    input logic  m_tvalid,
    input logic  m_tready,
    input logic [byte_round(2*ATOM_INDEX_WIDTH+3*FORCE_W)-1:0] m_tdata,
    input logic [0:0] m_tuser
);
    localparam int IW = ATOM_INDEX_WIDTH;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[2*IW +: 3*FORCE_W] == '0)
        else $error("coincident atoms gave nonzero force");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with a free pipeline");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind bond_spring_force_core bsf_checker #(
    .COORD_WIDTH      (COORD_WIDTH),
    .ATOM_INDEX_WIDTH (ATOM_INDEX_WIDTH)
) u_bsf_checker (.*);
`default_nettype wire

[sim/testbench.sv]
// Testbench for bond_spring_force_core: streams bonds, predicts each harmonic force result
// and checks the m_ transfers in order. Depends on bsf_pkg and the core RTL only.
`timescale 1ns / 1ps
module testbench;
    import bsf_pkg::*;

    localparam int AW = ATOM_INDEX_WIDTH_DEF;
    localparam int CW = COORD_WIDTH_DEF;
    localparam int SW = byte_round(2*AW + 6*CW + K_W + REST_W);
    localparam int MW = byte_round(2*AW + 3*FORCE_W);
    localparam int LATENCY = 3 + (CW + 1) + 33 + 4;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [31:0] rest;
        logic [31:0] k;
        logic [31:0] bz, by, bx;
        logic [31:0] az, ay, ax;
        logic [15:0] second;
        logic [15:0] first;
    } bond_t;

    typedef struct packed {
        logic        zero_len;
        logic [31:0] fz, fy, fx;
        logic [15:0] second;
        logic [15:0] first;
    } force_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [MW-1:0] m_tdata;
    logic [0:0] m_tuser;

    bond_t pending_bonds[$];
    force_t expected_forces[$];
    int errors = 0;
    int cycles = 0;
    int phase = 0;
    int hold_off = 0;
    bit in_taken = 0;
    bit stim_done = 0;

    bond_spring_force_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic void queue_bond(bond_t b);
        pending_bonds = {pending_bonds, b};
    endfunction

    function automatic logic [31:0] saturate_force(logic signed [63:0] e, logic [31:0] k);
        logic [127:0] p;
        logic [127:0] mag;
        mag = e < 0 ? 128'(-e) : 128'(e);
        p = (mag * k) >> FORCE_SHIFT;
        if (e >= 0)
            return p > 128'h7FFF_FFFF ? 32'h7FFF_FFFF : p[31:0];
        return p > 128'h8000_0000 ? 32'h8000_0000 : 32'(-p[31:0]);
    endfunction

    function automatic force_t bond_force(bond_t b);
        force_t f;
        logic signed [63:0] d[3];
        logic [127:0] sq, root, trial, q;
        logic [63:0] mag;
        logic signed [63:0] t;
        d[0] = 64'($signed(b.ax)) - 64'($signed(b.bx));
        d[1] = 64'($signed(b.ay)) - 64'($signed(b.by));
        d[2] = 64'($signed(b.az)) - 64'($signed(b.bz));
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            mag = d[i] < 0 ? -d[i] : d[i];
            sq += 128'(mag) * 128'(mag);
        end
        f.first = b.first;
        f.second = b.second;
        f.fx = 0; f.fy = 0; f.fz = 0;
        f.zero_len = (sq == 0);
        if (sq != 0) begin
            root = 0;
            for (int i = 63; i >= 0; i--) begin
                trial = root | (128'd1 << i);
                if (trial * trial <= sq) root = trial;
            end
            for (int i = 0; i < 3; i++) begin
                mag = d[i] < 0 ? -d[i] : d[i];
                q = (128'(b.rest) * 128'(mag)) / root;
                t = d[i] < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
                if (i == 0) f.fx = saturate_force(d[i] - t, b.k);
                if (i == 1) f.fy = saturate_force(d[i] - t, b.k);
                if (i == 2) f.fz = saturate_force(d[i] - t, b.k);
            end
        end
        return f;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 'h60000)) - 'h30000);
            3: return 32'($signed($urandom_range(0, 'h2000000)) - 'h1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic bond_t random_bond();
        bond_t b;
        b.first = 16'($urandom);
        b.second = $urandom_range(0, 7) == 0 ? b.first : 16'($urandom);
        b.ax = rand_coord(); b.ay = rand_coord(); b.az = rand_coord();
        case ($urandom_range(0, 4))
            0: begin b.bx = b.ax; b.by = b.ay; b.bz = b.az; end
            1: begin
                b.bx = b.ax + $urandom_range(0, 'h40000) - 'h20000;
                b.by = b.ay + $urandom_range(0, 'h40000) - 'h20000;
                b.bz = b.az + $urandom_range(0, 'h40000) - 'h20000;
            end
            default: begin b.bx = rand_coord(); b.by = rand_coord(); b.bz = rand_coord(); end
        endcase
        b.k = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 'h100000);
        b.rest = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 'h40000);
        return b;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial begin
        bond_t b;
        b = '0;
        queue_bond(b);
        b = '1;
        queue_bond(b);
        b = '0; b.k = '1; b.ax = 32'h7FFF_FFFF; b.bx = 32'h8000_0000;
        queue_bond(b);
        b.rest = '1; b.ay = 32'h8000_0000; b.by = 32'h7FFF_FFFF;
        queue_bond(b);
        b = '0; b.first = 16'hFFFF; b.second = 16'hFFFF; b.k = 32'h0001_0000;
        b.ax = 32'h0003_0000; b.ay = 32'h0004_0000; b.rest = 32'h0005_0000;
        queue_bond(b);
        b.rest = 32'h0002_0000;
        queue_bond(b);
        b.ax = 32'h0000_0001; b.ay = 0; b.rest = '1; b.k = '1;
        queue_bond(b);
        b.ax = 32'hFFFF_FFFF; b.bz = 32'h8000_0000; b.az = 32'h7FFF_FFFF;
        queue_bond(b);
        for (int i = 0; i < 12; i++) queue_bond(random_bond());
        for (int i = 0; i < 1130; i++) queue_bond(random_bond());
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (pending_bonds.size() > 0 &&
                    (phase == 2 || $urandom_range(0, 99) >= (phase == 0 ? 29 : 85))) begin
                    s_tvalid <= 1;
                    s_tdata <= SW'(pending_bonds[0]);
                end else begin
                    s_tvalid <= 0;
                end
            end
            if (hold_off > 0)
                m_tready <= 0;
            else
                m_tready <= phase == 2 || $urandom_range(0, 99) >= (phase == 0 ? 85 : 29);
        end
    end

    always @(posedge aclk) begin
        if (cycles == 300) hold_off <= 400;
        else if (hold_off > 0) hold_off <= hold_off - 1;
    end

    always @(posedge aclk) begin
        force_t got, want;
        cycles <= cycles + 1;
        in_taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_forces = {expected_forces, bond_force(s_tdata[$bits(bond_t)-1:0])};
            void'(pending_bonds.pop_front());
        end
        if (pending_bonds.size() < 800 && phase == 0) phase <= 1;
        if (pending_bonds.size() < 400 && phase == 1) phase <= 2;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[0], m_tdata[2*AW+3*FORCE_W-1:0]};
            if (expected_forces.size() == 0) begin
                report_mismatch("unexpected result", got.first, 0);
            end else begin
                want = expected_forces.pop_front();
                if (got.first != want.first) report_mismatch("first", got.first, want.first);
                if (got.second != want.second)
                    report_mismatch("second", got.second, want.second);
                if (got.fx != want.fx) report_mismatch("force_x", got.fx, want.fx);
                if (got.fy != want.fy) report_mismatch("force_y", got.fy, want.fy);
                if (got.fz != want.fz) report_mismatch("force_z", got.fz, want.fz);
                if (got.zero_len != want.zero_len)
                    report_mismatch("zero_length", got.zero_len, want.zero_len);
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        wait (pending_bonds.size() == 0 && !s_tvalid);
        wait (expected_forces.size() == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        if (errors == 0 && expected_forces.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end
endmodule
